@@ sv/tbcbp_pkg.sv @@
// Shared constants for the ternary/binary channel bit packer.
// Field widths, register indexes and mode codes; no dependencies.
package tbcbp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SLOT_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int MODE_W     = 2;
    localparam int CHCNT_W    = 13;
    localparam int DIM_W      = 11;
    localparam int DIM_POS_W  = 10;
    localparam int PAD_W      = 4;
    localparam int MAX_DIM    = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd5;

    localparam logic [MODE_W-1:0] MODE_TERNARY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BINARY_TH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BINARY_Z  = 2'd2;

endpackage

@@ sv/ternary_binary_channel_bit_packer_top.sv @@
// Ternary/binary activation quantizer with channel bit packing, top level.
// Depends on tbcbp_pkg for widths, register indexes and mode codes.
//
// One sample word is accepted per cycle with no bubbles while results drain; a packed word
// comes out of a result register the cycle after the sample closing its channel group,
// and while that word is held by a stall the input is stalled as well. After reset and
// after every write to registers 0 to 5 the input is stalled in states S_DIM to S_SUM
// while a short multiply chain derives the group count, padded width and slot increments
// from them. The configuration port is always ready; padding slots are never written out.
module ternary_binary_channel_bit_packer_top #(
    parameter int GROUP_BITS   = 64,
    parameter int MAX_CHANNELS = 4096
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic signed [tbcbp_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic signed [tbcbp_pkg::SAMPLE_W-1:0]    i_threshold,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic        [tbcbp_pkg::SLOT_W-1:0]      o_slot_index,
    output logic        [GROUP_BITS-1:0]             o_plane_low,
    output logic        [GROUP_BITS-1:0]             o_plane_high,
    output logic                                     o_image_done,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic        [tbcbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [tbcbp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tbcbp_pkg::*;

    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int CE_W   = CH_W + 1;
    localparam int BIT_W  = $clog2(GROUP_BITS);
    localparam int DV_W   = CE_W + 1;
    localparam int SH     = DV_W + BIT_W;
    localparam int R_W    = SH - BIT_W + 2;
    localparam int Q_W    = DV_W + R_W;
    localparam int PC_W   = DV_W - BIT_W + 1;
    localparam int PW_W   = DIM_W;
    localparam int PRPW_W = PAD_W + PW_W;
    localparam int ST_W   = PRPW_W + 1 + PC_W;
    localparam int CI_W   = PAD_W + 1 + PC_W;
    localparam int IR_W   = PAD_W + 1 + PW_W;
    localparam int II_W   = IR_W + PC_W;
    localparam logic [R_W-1:0] RECIP =
        R_W'(((longint'(1) << SH) + longint'(GROUP_BITS) - 1) / longint'(GROUP_BITS));

    typedef enum logic [5:0] {
        S_RUN = 6'b000001,
        S_DIM = 6'b000010,
        S_DIV = 6'b000100,
        S_MUL = 6'b001000,
        S_INC = 6'b010000,
        S_SUM = 6'b100000
    } t_cfg_state;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] e;
        if (d == '0) begin
            e = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            e = DIM_W'(MAX_DIM);
        end else begin
            e = d;
        end
        return e;
    endfunction

    t_cfg_state            r_state;
    logic [MODE_W-1:0]     r_mode;
    logic [CHCNT_W-1:0]    r_channel_count;
    logic [DIM_W-1:0]      r_image_height;
    logic [DIM_W-1:0]      r_image_width;
    logic [PAD_W-1:0]      r_pad_rows;
    logic [PAD_W-1:0]      r_pad_cols;

    logic [CE_W-1:0]       r_c_eff;
    logic [CH_W-1:0]       r_c_last;
    logic [DIM_POS_W-1:0]  r_h_last;
    logic [DIM_POS_W-1:0]  r_w_last;
    logic [PW_W-1:0]       r_pw;
    logic [PC_W-1:0]       r_pc;
    logic [PRPW_W-1:0]     r_prpw;
    logic [SLOT_W-1:0]     r_start;
    logic [SLOT_W-1:0]     r_col_inc;
    logic [IR_W-1:0]       r_img_rows;
    logic [SLOT_W-1:0]     r_img_inc;
    logic [SLOT_W-1:0]     r_row_inc;
    logic [SLOT_W-1:0]     r_img_end_inc;

    logic [CH_W-1:0]       r_ch_pos;
    logic [BIT_W-1:0]      r_bit;
    logic [DIM_POS_W-1:0]  r_col_pos;
    logic [DIM_POS_W-1:0]  r_row_pos;
    logic [GROUP_BITS-1:0] r_acc_lo;
    logic [GROUP_BITS-1:0] r_acc_hi;
    logic [SLOT_W-1:0]     r_running;

    logic                  r_out_valid;
    logic [SLOT_W-1:0]     r_out_slot;
    logic [GROUP_BITS-1:0] r_out_lo;
    logic [GROUP_BITS-1:0] r_out_hi;
    logic                  r_out_done;

    logic                  cfg_hit;
    logic                  in_acc;
    logic [CE_W-1:0]       c_eff;
    logic [DIM_W-1:0]      h_eff;
    logic [DIM_W-1:0]      w_eff;
    logic [Q_W-1:0]        div_prod;
    logic [PRPW_W-1:0]     prpw_prod;
    logic [ST_W-1:0]       start_prod;
    logic [CI_W-1:0]       col_prod;
    logic [IR_W-1:0]       rows_prod;
    logic [II_W-1:0]       img_prod;

    logic signed [SAMPLE_W:0] x_ext;
    logic signed [SAMPLE_W:0] th_ext;
    logic signed [SAMPLE_W:0] neg_th;
    logic                  lo_hit;
    logic                  hi_hit;
    logic [GROUP_BITS-1:0] mask;
    logic [GROUP_BITS-1:0] n_acc_lo;
    logic [GROUP_BITS-1:0] n_acc_hi;
    logic                  last_ch;
    logic                  last_bit;
    logic                  last_col;
    logic                  last_row;
    logic                  closes;
    logic [SLOT_W-1:0]     n_running;

    assign cfg_hit     = i_cfg_valid && (i_cfg_index <= REG_PAD_COLS);
    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_RUN) || (r_out_valid && i_stall);
    assign in_acc      = i_valid && !o_stall;

    always_comb begin
        if (r_channel_count == '0) begin
            c_eff = CE_W'(1);
        end else if (32'(r_channel_count) > MAX_CHANNELS) begin
            c_eff = CE_W'(MAX_CHANNELS);
        end else begin
            c_eff = CE_W'(r_channel_count);
        end
        h_eff      = eff_dim(r_image_height);
        w_eff      = eff_dim(r_image_width);
        div_prod   = Q_W'(DV_W'(r_c_eff) + DV_W'(GROUP_BITS - 1)) * Q_W'(RECIP);
        prpw_prod  = PRPW_W'(r_pad_rows) * PRPW_W'(r_pw);
        start_prod = (ST_W'(r_prpw) + ST_W'(r_pad_cols)) * ST_W'(r_pc);
        col_prod   = CI_W'({r_pad_cols, 1'b0}) * CI_W'(r_pc);
        rows_prod  = IR_W'({r_pad_rows, 1'b0}) * IR_W'(r_pw);
        img_prod   = II_W'(r_img_rows) * II_W'(r_pc);
    end

    always_comb begin
        x_ext  = {i_sample[SAMPLE_W-1], i_sample};
        th_ext = {i_threshold[SAMPLE_W-1], i_threshold};
        neg_th = -th_ext;
        lo_hit = 1'b0;
        hi_hit = 1'b0;
        unique case (r_mode)
            MODE_TERNARY: begin
                hi_hit = (x_ext > th_ext) || (x_ext < neg_th);
                lo_hit = !(x_ext > th_ext) && (x_ext < neg_th);
            end
            MODE_BINARY_TH: begin
                lo_hit = i_sample < i_threshold;
            end
            default: begin
                lo_hit = i_sample[SAMPLE_W-1];
            end
        endcase
        mask     = GROUP_BITS'(1) << r_bit;
        n_acc_lo = lo_hit ? (r_acc_lo | mask) : r_acc_lo;
        n_acc_hi = hi_hit ? (r_acc_hi | mask) : r_acc_hi;
        last_ch  = r_ch_pos == r_c_last;
        last_bit = r_bit == BIT_W'(GROUP_BITS - 1);
        last_col = r_col_pos == r_w_last;
        last_row = r_row_pos == r_h_last;
        closes   = last_ch || last_bit;
        if (last_ch && last_col && last_row) begin
            n_running = r_running + r_img_end_inc;
        end else if (last_ch && last_col) begin
            n_running = r_running + r_row_inc;
        end else begin
            n_running = r_running + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_DIM;
            r_mode          <= MODE_TERNARY;
            r_channel_count <= CHCNT_W'(64);
            r_image_height  <= DIM_W'(1);
            r_image_width   <= DIM_W'(1);
            r_pad_rows      <= '0;
            r_pad_cols      <= '0;
        end else if (cfg_hit) begin
            r_state <= S_DIM;
            unique case (i_cfg_index)
                REG_MODE:          r_mode          <= i_cfg_data[MODE_W-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CHCNT_W-1:0];
                REG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[DIM_W-1:0];
                REG_PAD_ROWS:      r_pad_rows      <= i_cfg_data[PAD_W-1:0];
                default:           r_pad_cols      <= i_cfg_data[PAD_W-1:0];
            endcase
        end else begin
            unique case (r_state)
                S_DIM:   r_state <= S_DIV;
                S_DIV:   r_state <= S_MUL;
                S_MUL:   r_state <= S_INC;
                S_INC:   r_state <= S_SUM;
                default: r_state <= S_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_DIM: begin
                r_c_eff  <= c_eff;
                r_c_last <= CH_W'(c_eff - CE_W'(1));
                r_h_last <= DIM_POS_W'(h_eff - DIM_W'(1));
                r_w_last <= DIM_POS_W'(w_eff - DIM_W'(1));
                r_pw     <= w_eff + PW_W'({r_pad_cols, 1'b0});
            end
            S_DIV: begin
                r_pc   <= div_prod[SH +: PC_W];
                r_prpw <= prpw_prod;
            end
            S_MUL: begin
                r_start    <= SLOT_W'(start_prod);
                r_col_inc  <= SLOT_W'(col_prod);
                r_img_rows <= rows_prod;
            end
            S_INC: begin
                r_img_inc <= SLOT_W'(img_prod);
                r_row_inc <= r_col_inc + SLOT_W'(1);
            end
            S_SUM: begin
                r_img_end_inc <= r_row_inc + r_img_inc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_ch_pos  <= '0;
            r_bit     <= '0;
            r_col_pos <= '0;
            r_row_pos <= '0;
            r_acc_lo  <= '0;
            r_acc_hi  <= '0;
        end else if (r_state == S_SUM) begin
            r_running <= r_start;
        end else if (in_acc) begin
            if (closes) begin
                r_acc_lo  <= '0;
                r_acc_hi  <= '0;
                r_bit     <= '0;
                r_running <= n_running;
            end else begin
                r_acc_lo <= n_acc_lo;
                r_acc_hi <= n_acc_hi;
                r_bit    <= r_bit + BIT_W'(1);
            end
            if (last_ch) begin
                r_ch_pos <= '0;
                if (last_col) begin
                    r_col_pos <= '0;
                    r_row_pos <= last_row ? '0 : r_row_pos + DIM_POS_W'(1);
                end else begin
                    r_col_pos <= r_col_pos + DIM_POS_W'(1);
                end
            end else begin
                r_ch_pos <= r_ch_pos + CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && closes) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && closes) begin
            r_out_slot <= r_running;
            r_out_lo   <= n_acc_lo;
            r_out_hi   <= (r_mode == MODE_TERNARY) ? n_acc_hi : '0;
            r_out_done <= last_ch && last_col && last_row;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_plane_low  = r_out_lo;
    assign o_plane_high = r_out_hi;
    assign o_image_done = r_out_done;

endmodule

@@ sv/tbcbp_checker.sv @@
// Port-level checks for the channel bit packer, bound to the top level.
// Depends on tbcbp_pkg for widths and register indexes.
module tbcbp_checker #(
    parameter int GROUP_BITS = 64
) (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    o_stall,
    input logic                                    o_valid,
    input logic                                    i_stall,
    input logic [tbcbp_pkg::SLOT_W-1:0]            o_slot_index,
    input logic [GROUP_BITS-1:0]                   o_plane_low,
    input logic [GROUP_BITS-1:0]                   o_plane_high,
    input logic                                    o_image_done,
    input logic                                    i_cfg_valid,
    input logic                                    o_cfg_ready,
    input logic [tbcbp_pkg::CFG_IDX_W-1:0]         i_cfg_index
);
    import tbcbp_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("output not quiet after reset");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready && (i_cfg_index <= REG_PAD_COLS) |=> o_stall)
        else $error("input not held after register write");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_slot_index) && $stable(o_plane_low)
            && $stable(o_plane_high) && $stable(o_image_done))
        else $error("stalled result changed");

endmodule

bind ternary_binary_channel_bit_packer_top tbcbp_checker #(
    .GROUP_BITS(GROUP_BITS)
) u_tbcbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_slot_index (o_slot_index),
    .o_plane_low  (o_plane_low),
    .o_plane_high (o_plane_high),
    .o_image_done (o_image_done),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready),
    .i_cfg_index  (i_cfg_index)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the ternary/binary channel bit packer: predicts every packed word and
// checks it field by field under random bursts, stalls and register settings.
// Depends on tbcbp_pkg and ternary_binary_channel_bit_packer_top.

module tb;
    import tbcbp_pkg::*;

    localparam int SETTLE      = 8;
    localparam int PACK_BITS   = 64;
    localparam int CHANNEL_CAP = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B   = 3'd7;
    localparam logic [MODE_W-1:0]    MODE_RESERVED = 2'd3;

    typedef struct {
        logic [SLOT_W-1:0]    slot;
        logic [PACK_BITS-1:0] low;
        logic [PACK_BITS-1:0] high;
        logic                 done;
    } t_packed_word;

    class slot_scoreboard;
        t_packed_word         words_due[$];
        int                   mismatches;
        logic [MODE_W-1:0]    mode;
        logic [CHCNT_W-1:0]   chans;
        logic [DIM_W-1:0]     rows_cfg;
        logic [DIM_W-1:0]     cols_cfg;
        logic [PAD_W-1:0]     pad_r;
        logic [PAD_W-1:0]     pad_c;
        int unsigned          chan_pos;
        int unsigned          col_pos;
        int unsigned          row_pos;
        logic [SLOT_W-1:0]    next_slot;
        logic [PACK_BITS-1:0] low_acc;
        logic [PACK_BITS-1:0] high_acc;

        function new();
            mismatches = 0;
            mode = MODE_TERNARY;
            chans = CHCNT_W'(64);
            rows_cfg = DIM_W'(1);
            cols_cfg = DIM_W'(1);
            pad_r = '0;
            pad_c = '0;
            restart();
        endfunction

        function int unsigned live_channels();
            int unsigned c;
            c = chans;
            if (c == 0) c = 1;
            if (c > CHANNEL_CAP) c = CHANNEL_CAP;
            return c;
        endfunction

        function int unsigned live_dim(int unsigned d);
            if (d == 0) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return d;
        endfunction

        function int unsigned groups();
            return (live_channels() + PACK_BITS - 1) / PACK_BITS;
        endfunction

        function int unsigned padded_width();
            int unsigned pc;
            pc = pad_c;
            return live_dim(cols_cfg) + 2 * pc;
        endfunction

        function void restart();
            int unsigned pr, pc;
            pr = pad_r;
            pc = pad_c;
            chan_pos = 0;
            col_pos = 0;
            row_pos = 0;
            low_acc = '0;
            high_acc = '0;
            next_slot = (pr * padded_width() + pc) * groups();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:          mode = data[MODE_W-1:0];
                REG_CHANNEL_COUNT: chans = data[CHCNT_W-1:0];
                REG_IMAGE_HEIGHT:  rows_cfg = data[DIM_W-1:0];
                REG_IMAGE_WIDTH:   cols_cfg = data[DIM_W-1:0];
                REG_PAD_ROWS:      pad_r = data[PAD_W-1:0];
                REG_PAD_COLS:      pad_c = data[PAD_W-1:0];
                default:           return;
            endcase
            restart();
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x,
                                  logic signed [SAMPLE_W-1:0] th);
            int           xv, tv;
            int unsigned  bit_no, pr, pc;
            bit           last_ch;
            t_packed_word w;
            xv = x;
            tv = th;
            pr = pad_r;
            pc = pad_c;
            bit_no = chan_pos % PACK_BITS;
            last_ch = (chan_pos + 1 >= live_channels());
            if (mode == MODE_TERNARY) begin
                if (xv > tv) begin
                    high_acc[bit_no] = 1'b1;
                end else if (xv < -tv) begin
                    low_acc[bit_no] = 1'b1;
                    high_acc[bit_no] = 1'b1;
                end
            end else if (mode == MODE_BINARY_TH) begin
                if (xv < tv) low_acc[bit_no] = 1'b1;
            end else if (xv < 0) begin
                low_acc[bit_no] = 1'b1;
            end
            if (!last_ch && bit_no != PACK_BITS - 1) begin
                chan_pos++;
                return;
            end
            w.slot = next_slot;
            w.done = 1'b0;
            next_slot = next_slot + 1;
            if (last_ch) begin
                chan_pos = 0;
                if (col_pos + 1 >= live_dim(cols_cfg)) begin
                    col_pos = 0;
                    next_slot = next_slot + 2 * pc * groups();
                    if (row_pos + 1 >= live_dim(rows_cfg)) begin
                        row_pos = 0;
                        w.done = 1'b1;
                        next_slot = next_slot + 2 * pr * padded_width() * groups();
                    end else begin
                        row_pos++;
                    end
                end else begin
                    col_pos++;
                end
            end else begin
                chan_pos++;
            end
            w.low = low_acc;
            w.high = (mode == MODE_TERNARY) ? high_acc : '0;
            words_due.push_back(w);
            low_acc = '0;
            high_acc = '0;
        endfunction

        task report_mismatch(string field, logic [SLOT_W-1:0] at_slot,
                             logic [PACK_BITS-1:0] got, logic [PACK_BITS-1:0] want);
            if (mismatches < 100)
                $display("tb: mismatch in %s at slot %0d: got %h, want %h",
                         field, at_slot, got, want);
            mismatches++;
        endtask

        task check_word(logic [SLOT_W-1:0] slot, logic [PACK_BITS-1:0] low,
                        logic [PACK_BITS-1:0] high, logic done);
            t_packed_word want;
            if (words_due.size() == 0) begin
                report_mismatch("word with none due", slot, low, '0);
                return;
            end
            want = words_due.pop_front();
            if (slot !== want.slot)
                report_mismatch("slot_index", want.slot, PACK_BITS'(slot),
                                PACK_BITS'(want.slot));
            if (low !== want.low) report_mismatch("plane_low", want.slot, low, want.low);
            if (high !== want.high)
                report_mismatch("plane_high", want.slot, high, want.high);
            if (done !== want.done)
                report_mismatch("image_done", want.slot, PACK_BITS'(done),
                                PACK_BITS'(want.done));
        endtask
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic signed [SAMPLE_W-1:0]  i_threshold;
    logic                        o_valid;
    logic                        i_stall;
    logic [SLOT_W-1:0]           o_slot_index;
    logic [PACK_BITS-1:0]        o_plane_low;
    logic [PACK_BITS-1:0]        o_plane_high;
    logic                        o_image_done;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    slot_scoreboard              book;
    int unsigned                 hold_left;
    int unsigned                 burst_left;
    logic signed [SAMPLE_W-1:0]  image_th;

    ternary_binary_channel_bit_packer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_threshold  (i_threshold),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_slot_index (o_slot_index),
        .o_plane_low  (o_plane_low),
        .o_plane_high (o_plane_high),
        .o_image_done (o_image_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin : receiver_stalls
        int unsigned run_left, stall_pct;
        run_left = 0;
        stall_pct = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 80);
                    stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 75);
                end
                run_left--;
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin : word_monitor
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                book.check_word(o_slot_index, o_plane_low, o_plane_high, o_image_done);
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_threshold();
        int v;
        case ($urandom_range(0, 4))
            0:       v = $urandom_range(0, 65535);
            1:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            2:       v = 0;
            default: v = $urandom_range(0, 8191);
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
        logic signed [SAMPLE_W-1:0] th);
        int v, t, r;
        t = th;
        r = $urandom_range(0, 4);
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 65535);
            1:       v = t + r - 2;
            2:       v = -t + r - 2;
            3:       v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: v = $urandom_range(0, 16383) - 8192;
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(logic signed [SAMPLE_W-1:0] x,
                               logic signed [SAMPLE_W-1:0] th);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_sample <= x;
        i_threshold <= th;
        do @(posedge i_clk); while (o_stall);
        book.note_sample(x, th);
    endtask

    task automatic wait_idle();
        while (book.words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.write_reg(idx, data);
    endtask

    task automatic load_config(logic [MODE_W-1:0] m, logic [CFG_DATA_W-1:0] c,
                               logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] w,
                               logic [PAD_W-1:0] pr, logic [PAD_W-1:0] pc, bit spare);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        write_reg(REG_MODE, {noise[CFG_DATA_W-1:MODE_W], m});
        write_reg(REG_CHANNEL_COUNT, c);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_IMAGE_WIDTH, w);
        noise = CFG_DATA_W'($urandom);
        write_reg(REG_PAD_ROWS, {noise[CFG_DATA_W-1:PAD_W], pr});
        noise = CFG_DATA_W'($urandom);
        write_reg(REG_PAD_COLS, {noise[CFG_DATA_W-1:PAD_W], pc});
        if (spare) begin
            noise = CFG_DATA_W'($urandom);
            write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, noise);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int unsigned n_items, bit with_hold);
        for (int k = 0; k < n_items; k++) begin
            if (k == 0 || $urandom_range(0, 39) == 0) image_th = pick_threshold();
            if (with_hold && k == 30) hold_left = 400;
            send_sample(pick_sample(image_th), image_th);
        end
        i_valid <= 1'b0;
        wait_idle();
    endtask

    task automatic random_config_phase();
        logic [CFG_DATA_W-1:0] c, h, w;
        c = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(60, 200))
                                        : CFG_DATA_W'($urandom_range(1, 20));
        h = CFG_DATA_W'($urandom_range(1, 3))
            | (($urandom_range(0, 1) != 0) ? 13'h1800 : 13'h0);
        w = CFG_DATA_W'($urandom_range(1, 3))
            | (($urandom_range(0, 1) != 0) ? 13'h1800 : 13'h0);
        load_config(MODE_W'($urandom_range(0, 3)), c, h, w,
                    PAD_W'($urandom_range(0, 15)), PAD_W'($urandom_range(0, 15)), 1'b1);
        random_phase($urandom_range(40, 60), 1'b0);
    endtask

    initial begin
        book = new();
        hold_left = 0;
        burst_left = 0;
        image_th = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_threshold = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MODE;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: ternary, 64 channels, one pixel per image
        send_sample(16'sd32767, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd100, 16'sd50);
        send_sample(-16'sd100, 16'sd50);
        send_sample(-16'sd50, 16'sd50);
        send_sample(16'sd50, 16'sd50);
        send_sample(16'sh8000, 16'sd32767);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sh8000, 16'sd0);
        send_sample(16'sd32767, 16'sd0);
        for (int k = 0; k < 52; k++) send_sample(pick_sample(16'sd300), 16'sd300);
        i_valid <= 1'b0;
        wait_idle();

        load_config(MODE_BINARY_TH, 13'd3, 13'd2, 13'd1, 4'd1, 4'd1, 1'b0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(16'sh8000, 16'sd32767);
        i_valid <= 1'b0;
        wait_idle();

        load_config(MODE_BINARY_Z, 13'd2, 13'd1, 13'd1, 4'd0, 4'd0, 1'b0);
        send_sample(-16'sd1, -16'sd100);
        send_sample(16'sd0, -16'sd100);
        send_sample(16'sh8000, 16'sd32767);
        send_sample(16'sd32767, 16'sh8000);
        i_valid <= 1'b0;
        wait_idle();

        // spare register write in mid group must leave the stream alone
        load_config(MODE_RESERVED, 13'd2, 13'd1, 13'd1, 4'd0, 4'd0, 1'b0);
        send_sample(-16'sd5, -16'sd100);
        i_valid <= 1'b0;
        wait_idle();
        write_reg(REG_SPARE_B, 13'h1fff);
        i_cfg_valid <= 1'b0;
        send_sample(16'sd5, 16'sd100);
        i_valid <= 1'b0;
        wait_idle();

        load_config(MODE_TERNARY, 13'd1, 13'd3, 13'd4, 4'd2, 4'd3, 1'b1);
        random_phase(120, 1'b1);
        load_config(MODE_BINARY_TH, 13'd70, 13'd2, 13'd2, 4'd0, 4'd15, 1'b0);
        random_phase(150, 1'b0);
        load_config(MODE_BINARY_Z, 13'd130, 13'd1, 13'd1, 4'd15, 4'd0, 1'b1);
        random_phase(100, 1'b0);
        load_config(MODE_TERNARY, 13'd4096, 13'd1024, 13'd1024, 4'd15, 4'd15, 1'b0);
        random_phase(140, 1'b0);
        load_config(MODE_RESERVED, 13'd0, 13'd0, 13'd0, 4'd0, 4'd0, 1'b1);
        random_phase(50, 1'b0);
        load_config(MODE_BINARY_TH, 13'h1fff, 13'h1fff, 13'h1fff, 4'd15, 4'd15, 1'b0);
        random_phase(70, 1'b0);
        repeat (4) random_config_phase();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (book.mismatches == 0 && book.words_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
